FILE: src/kt2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kt2d_pkg
// Fixed-point types and helpers for the 2-D Kalman tracker (signed Q32.16).
// ---------------------------------------------------------------------------
package kt2d_pkg;

	localparam int FX_W = 48;

	typedef logic signed [FX_W-1:0] fx_t;

	localparam fx_t FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
	localparam fx_t FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

	typedef struct packed {
		logic start;
		logic op_div;
	} arith_req_t;

	typedef struct packed {
		logic done;
	} arith_rsp_t;

	function automatic fx_t fx_sat49(input logic signed [FX_W:0] v);
		if (v[FX_W] != v[FX_W-1]) begin
			return v[FX_W] ? FX_MIN : FX_MAX;
		end
		return v[FX_W-1:0];
	endfunction

	function automatic fx_t fx_add(input fx_t a, input fx_t b);
		return fx_sat49({a[FX_W-1], a} + {b[FX_W-1], b});
	endfunction

	function automatic fx_t fx_sub(input fx_t a, input fx_t b);
		return fx_sat49({a[FX_W-1], a} - {b[FX_W-1], b});
	endfunction

	// multiply by one half, magnitude rounded with ties away from zero
	function automatic fx_t fx_half(input fx_t v);
		logic [FX_W-1:0] mag;
		logic [FX_W:0]   m2;
		mag = v[FX_W-1] ? FX_W'(-v) : FX_W'(v);
		m2  = ({1'b0, mag} + (FX_W+1)'(1)) >> 1;
		return v[FX_W-1] ? fx_t'(-m2[FX_W-1:0]) : fx_t'(m2[FX_W-1:0]);
	endfunction

	function automatic fx_t fx_signed_sat(input logic [63:0] mag, input logic neg);
		logic [63:0] lim;
		lim = 64'd1 << (FX_W - 1);
		if (neg) begin
			if (mag > lim) begin
				return FX_MIN;
			end
			return fx_t'(-mag[FX_W-1:0]);
		end
		if (mag >= lim) begin
			return FX_MAX;
		end
		return fx_t'(mag[FX_W-1:0]);
	endfunction

endpackage
`default_nettype wire

FILE: src/kt2d_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kt2d_ifs
// Valid/ready channels for measurement requests and position estimates.
// ---------------------------------------------------------------------------
interface kt2d_meas_if #(parameter int COORD_BITS = 13);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] meas_x;
	logic signed [COORD_BITS-1:0] meas_y;

	modport source (output valid, output meas_x, output meas_y, input ready);
	modport sink   (input valid, input meas_x, input meas_y, output ready);
endinterface

interface kt2d_est_if #(parameter int COORD_BITS = 13);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] est_x;
	logic signed [COORD_BITS-1:0] est_y;
	logic                         tracking;

	modport source (output valid, output est_x, output est_y, output tracking, input ready);
	modport sink   (input valid, input est_x, input est_y, input tracking, output ready);
endinterface
`default_nettype wire

FILE: src/kt2d_arith.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kt2d_arith
// Shared Q32.16 multiplier (one 24x24 product per cycle) and radix-4
// restoring divider, both sign-magnitude with saturation.
// ---------------------------------------------------------------------------
module kt2d_arith import kt2d_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  arith_req_t req,
	input  fx_t        op_a,
	input  fx_t        op_b,
	output arith_rsp_t rsp,
	output fx_t        result
);

	typedef enum logic [1:0] {A_IDLE, A_MUL, A_MAG, A_DIV} ast_t;

	ast_t              state_q;
	logic [4:0]        cnt_q;
	logic [FX_W-1:0]   ua_q, ub_q;
	logic              neg_q;
	logic [47:0]       hh_q, ll_q;
	logic [48:0]       mid_q;
	logic [FX_W-1:0]   rem_q, dq_q;
	fx_t               res_q;
	logic              done_q;

	logic [FX_W-1:0]   ma, mb;
	logic [23:0]       mx_a, mx_b;
	logic [47:0]       prod;
	logic [63:0]       mag;
	logic [FX_W:0]     r1, r2;
	logic              ge1, ge2;
	logic [FX_W-1:0]   r1s, r2s, dq2;

	assign ma = op_a[FX_W-1] ? FX_W'(-op_a) : FX_W'(op_a);
	assign mb = op_b[FX_W-1] ? FX_W'(-op_b) : FX_W'(op_b);

	// partial products: high*high, high*low, low*high, low*low
	assign mx_a = (cnt_q < 5'd2) ? ua_q[47:24] : ua_q[23:0];
	assign mx_b = (cnt_q == 5'd0 || cnt_q == 5'd2) ? ub_q[47:24] : ub_q[23:0];
	assign prod = 48'(mx_a) * 48'(mx_b);

	always_comb begin
		if (hh_q >= 48'd32768) begin
			mag = 64'd1 << 48;
		end else begin
			mag = (64'(hh_q) << 32) + (64'(mid_q) << 8)
				+ (64'({1'b0, ll_q} + 49'd32768) >> 16);
		end
	end

	// two quotient bits per cycle
	always_comb begin
		r1  = {rem_q, dq_q[FX_W-1]};
		ge1 = r1 >= {1'b0, ub_q};
		r1s = ge1 ? FX_W'(r1 - {1'b0, ub_q}) : r1[FX_W-1:0];
		r2  = {r1s, dq_q[FX_W-2]};
		ge2 = r2 >= {1'b0, ub_q};
		r2s = ge2 ? FX_W'(r2 - {1'b0, ub_q}) : r2[FX_W-1:0];
		dq2 = {dq_q[FX_W-3:0], ge1, ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q   <= '0;
			ua_q    <= '0;
			ub_q    <= '0;
			neg_q   <= 1'b0;
			hh_q    <= '0;
			ll_q    <= '0;
			mid_q   <= '0;
			rem_q   <= '0;
			dq_q    <= '0;
			res_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						ua_q  <= ma;
						ub_q  <= mb;
						neg_q <= op_a[FX_W-1] != op_b[FX_W-1];
						cnt_q <= '0;
						if (!req.op_div) begin
							state_q <= A_MUL;
						end else if (mb == '0) begin
							res_q  <= '0;
							done_q <= 1'b1;
						end else if ({32'd0, ma[47:32]} >= mb) begin
							res_q  <= fx_signed_sat(64'hFFFF_FFFF_FFFF_FFFF,
								op_a[FX_W-1] != op_b[FX_W-1]);
							done_q <= 1'b1;
						end else begin
							rem_q   <= {32'd0, ma[47:32]};
							dq_q    <= {ma[31:0], 16'd0};
							state_q <= A_DIV;
						end
					end
				end
				A_MUL: begin
					case (cnt_q)
						5'd0:    hh_q  <= prod;
						5'd1:    mid_q <= {1'b0, prod};
						5'd2:    mid_q <= mid_q + {1'b0, prod};
						default: ll_q  <= prod;
					endcase
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd3) begin
						state_q <= A_MAG;
					end
				end
				A_MAG: begin
					res_q   <= fx_signed_sat(mag, neg_q);
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
				A_DIV: begin
					rem_q <= r2s;
					dq_q  <= dq2;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd23) begin
						res_q   <= fx_signed_sat({16'd0, dq2}, neg_q);
						done_q  <= 1'b1;
						state_q <= A_IDLE;
					end
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign result   = res_q;

endmodule
`default_nettype wire

FILE: src/kalman_tracker_2d_core.sv
`timescale 1ns / 1ps
`default_nettype none
// One request in flight: a new measurement is accepted only in idle, after the
// estimate of the last one is registered. The correction runs 2n+1 quotients
// and 2n^2+4n+1 products on the shared unit; each covariance memory read
// passes through the S_RD and S_RDV states.
// Reset is asynchronous: state vector and lock clear, covariance valid bits
// clear so every entry reads as the init_variance diagonal; no clearing pass.
// ---------------------------------------------------------------------------
// kalman_tracker_2d_core
// Per-frame 2-D Kalman tracker, constant velocity or acceleration model.
// ---------------------------------------------------------------------------
module kalman_tracker_2d_core import kt2d_pkg::*; #(
	parameter int MAX_STATES = 6,
	parameter int COORD_BITS = 13
) (
	input  wire          clk,
	input  wire          arst_n,
	kt2d_meas_if.sink    meas,
	kt2d_est_if.source   est,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [4:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int IW = $clog2(MAX_STATES);
	localparam int CW = $clog2(MAX_STATES + 1);
	localparam int DEPTH = MAX_STATES * MAX_STATES;
	localparam int AW = $clog2(DEPTH);
	localparam logic [2:0] REG_MODEL = 3'd0;
	localparam logic [2:0] REG_POS   = 3'd1;
	localparam logic [2:0] REG_VEL   = 3'd2;
	localparam logic [2:0] REG_ACC   = 3'd3;
	localparam logic [2:0] REG_MEAS  = 3'd4;
	localparam logic [2:0] REG_INITV = 3'd5;

	typedef enum logic [3:0] {
		S_IDLE, S_XPRED, S_RD, S_RDV, S_PWR, S_CHK, S_SETUP, S_ISSUE, S_WAIT, S_OUT
	} state_t;
	typedef enum logic [2:0] {T_PRED, T_ROW0, T_ROWM, T_B0, T_B1, T_PIJ} rd_tag_t;
	typedef enum logic [3:0] {
		ST_L, ST_S11, ST_Y1A, ST_Y1, ST_Y0A, ST_Y0, ST_X0, ST_X1, ST_P0, ST_P1
	} step_t;

	// configuration
	logic        model_q;
	logic [15:0] posn_q, veln_q, accn_q, measn_q;
	logic [23:0] initv_q;
	logic [2:0]  cfg_idx;
	logic        cfg_we, restart;

	assign cfg_idx = paddr[4:2];
	assign cfg_we  = psel & penable & pwrite;
	assign restart = cfg_we && (cfg_idx == REG_MODEL || cfg_idx == REG_INITV);
	assign pready  = 1'b1;

	always_comb begin
		case (cfg_idx)
			REG_MODEL: prdata = {31'd0, model_q};
			REG_POS:   prdata = {16'd0, posn_q};
			REG_VEL:   prdata = {16'd0, veln_q};
			REG_ACC:   prdata = {16'd0, accn_q};
			REG_MEAS:  prdata = {16'd0, measn_q};
			REG_INITV: prdata = {8'd0, initv_q};
			default:   prdata = '0;
		endcase
	end

	// datapath state
	state_t                       state_q;
	rd_tag_t                      tag_q;
	step_t                        step_q;
	logic [CW-1:0]                i_q, j_q, ri_q, rj_q;
	logic [1:0]                   k_q;
	logic                         ph_q;
	logic                         locked_q;
	fx_t                          xv_q [MAX_STATES];
	fx_t                          row0_q [MAX_STATES];
	fx_t                          rowm_q [MAX_STATES];
	logic [DEPTH-1:0]             pv_q;
	fx_t                          acc_q, tmp_q, s00_q, s01_q, s11b_q, l_q;
	fx_t                          e0_q, e1_q, b0_q, b1_q, y0_q, y1_q;
	logic signed [COORD_BITS-1:0] zx_q, zy_q;
	logic                         ov_q, trk_q;
	logic signed [COORD_BITS-1:0] estx_q, esty_q;

	// covariance memory
	fx_t         pmem [DEPTH];
	fx_t         rd_q;
	logic        rvld_q, rdiag_q;
	logic [AW-1:0] raddr, waddr;
	logic        mem_we;
	fx_t         mem_wd, p_rd;

	logic [CW-1:0] nst, mst, bi;
	logic          more;
	fx_t           zx16, zy16, rnoise, xm, term, pwr_val, qv;
	fx_t           xp [MAX_STATES];
	fx_t           xext [MAX_STATES+2];

	arith_req_t    ar_req;
	arith_rsp_t    ar_rsp;
	fx_t           ar_a, ar_b, ar_res;

	function automatic logic [CW-1:0] blk(input logic [CW-1:0] idx, input logic [CW-1:0] m);
		return (idx < m) ? idx : CW'(idx - m);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] to_coord(input fx_t v);
		logic signed [FX_W:0] t;
		logic signed [FX_W:0] hi, lo;
		t  = $signed({v[FX_W-1], v} + (FX_W+1)'(32768)) >>> 16;
		hi = (FX_W+1)'((1 << (COORD_BITS - 1)) - 1);
		lo = -hi - (FX_W+1)'(1);
		if (t > hi) begin
			return COORD_BITS'(hi);
		end
		if (t < lo) begin
			return COORD_BITS'(lo);
		end
		return COORD_BITS'(t);
	endfunction

	assign nst    = (model_q && MAX_STATES >= 6) ? CW'(6) : CW'(4);
	assign mst    = CW'(nst >> 1);
	assign zx16   = fx_t'(zx_q) <<< 16;
	assign zy16   = fx_t'(zy_q) <<< 16;
	assign rnoise = fx_t'({measn_q, 16'd0});
	assign xm     = (mst == CW'(3)) ? xv_q[3] : xv_q[2];

	// predicted state: x = A x, with the measurement forced in until locked
	always_comb begin
		logic [CW-1:0] bb;
		fx_t           acc;
		for (int g = 0; g < MAX_STATES + 2; g++) begin
			xext[g] = (g < MAX_STATES) ? xv_q[g % MAX_STATES] : '0;
		end
		for (int g = 0; g < MAX_STATES; g++) begin
			bb  = blk(CW'(g), mst);
			acc = xv_q[g];
			if (CW'(bb + CW'(1)) < mst) begin
				acc = fx_add(acc, xext[g+1]);
			end
			if (CW'(bb + CW'(2)) < mst) begin
				acc = fx_add(acc, fx_half(xext[g+2]));
			end
			xp[g] = (CW'(g) < nst) ? acc : xv_q[g];
		end
		if (!locked_q) begin
			xp[0] = zx16;
			if (mst == CW'(3)) begin
				xp[3] = zy16;
			end else begin
				xp[2] = zy16;
			end
		end
	end

	// covariance predict term control
	assign bi   = ph_q ? blk(j_q, mst) : blk(i_q, mst);
	assign more = (k_q != 2'd2) && (CW'(bi + CW'(k_q) + CW'(1)) < mst);
	assign term = (k_q == 2'd2) ? fx_half(p_rd) : p_rd;

	always_comb begin
		case (blk(i_q, mst))
			CW'(0):  qv = fx_t'({posn_q, 16'd0});
			CW'(1):  qv = fx_t'({veln_q, 16'd0});
			default: qv = fx_t'({accn_q, 16'd0});
		endcase
	end
	assign pwr_val = (ph_q && i_q == j_q) ? fx_add(acc_q, qv) : acc_q;

	// memory addressing and read overlay
	assign raddr  = AW'(ri_q[IW-1:0] * MAX_STATES + rj_q[IW-1:0]);
	assign waddr  = AW'(i_q[IW-1:0] * MAX_STATES + j_q[IW-1:0]);
	assign mem_we = (state_q == S_PWR) ||
		(state_q == S_WAIT && ar_rsp.done && step_q == ST_P1);
	assign mem_wd = (state_q == S_PWR) ? pwr_val : fx_sub(tmp_q, ar_res);
	assign p_rd   = rvld_q ? rd_q : (rdiag_q ? fx_t'({initv_q, 16'd0}) : '0);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pmem[waddr] <= mem_wd;
		end
		if (state_q == S_RD) begin
			rd_q    <= pmem[raddr];
			rvld_q  <= pv_q[raddr];
			rdiag_q <= ri_q == rj_q;
		end
	end

	// shared arithmetic operands
	always_comb begin
		ar_req.start  = state_q == S_ISSUE;
		ar_req.op_div = step_q == ST_L || step_q == ST_Y1 || step_q == ST_Y0;
		case (step_q)
			ST_L:    begin ar_a = l_q;  ar_b = s00_q; end
			ST_S11:  begin ar_a = l_q;  ar_b = s01_q; end
			ST_Y1A:  begin ar_a = l_q;  ar_b = b0_q; end
			ST_Y1:   begin ar_a = tmp_q; ar_b = s11b_q; end
			ST_Y0A:  begin ar_a = s01_q; ar_b = y1_q; end
			ST_Y0:   begin ar_a = tmp_q; ar_b = s00_q; end
			ST_X0:   begin ar_a = y0_q; ar_b = e0_q; end
			ST_X1:   begin ar_a = y1_q; ar_b = e1_q; end
			ST_P0:   begin ar_a = y0_q; ar_b = row0_q[j_q[IW-1:0]]; end
			default: begin ar_a = y1_q; ar_b = rowm_q[j_q[IW-1:0]]; end
		endcase
	end

	kt2d_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ar_req),
		.op_a   (ar_a),
		.op_b   (ar_b),
		.rsp    (ar_rsp),
		.result (ar_res)
	);

	assign meas.ready   = state_q == S_IDLE;
	assign est.valid    = ov_q;
	assign est.est_x    = estx_q;
	assign est.est_y    = esty_q;
	assign est.tracking = trk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q  <= 1'b0;
			posn_q   <= 16'd25;
			veln_q   <= 16'd10;
			accn_q   <= 16'd1;
			measn_q  <= 16'd25;
			initv_q  <= 24'd1000000;
			state_q  <= S_IDLE;
			tag_q    <= T_PRED;
			step_q   <= ST_L;
			i_q      <= '0;
			j_q      <= '0;
			ri_q     <= '0;
			rj_q     <= '0;
			k_q      <= '0;
			ph_q     <= 1'b0;
			locked_q <= 1'b0;
			pv_q     <= '0;
			for (int g = 0; g < MAX_STATES; g++) begin
				xv_q[g]   <= '0;
				row0_q[g] <= '0;
				rowm_q[g] <= '0;
			end
			acc_q    <= '0;
			tmp_q    <= '0;
			s00_q    <= '0;
			s01_q    <= '0;
			s11b_q   <= '0;
			l_q      <= '0;
			e0_q     <= '0;
			e1_q     <= '0;
			b0_q     <= '0;
			b1_q     <= '0;
			y0_q     <= '0;
			y1_q     <= '0;
			zx_q     <= '0;
			zy_q     <= '0;
			ov_q     <= 1'b0;
			trk_q    <= 1'b0;
			estx_q   <= '0;
			esty_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_MODEL: model_q <= pwdata[0];
					REG_POS:   posn_q  <= pwdata[15:0];
					REG_VEL:   veln_q  <= pwdata[15:0];
					REG_ACC:   accn_q  <= pwdata[15:0];
					REG_MEAS:  measn_q <= pwdata[15:0];
					REG_INITV: initv_q <= pwdata[23:0];
					default:   ;
				endcase
			end
			if (restart) begin
				for (int g = 0; g < MAX_STATES; g++) begin
					xv_q[g] <= '0;
				end
				locked_q <= 1'b0;
				pv_q     <= '0;
			end
			if (est.valid && est.ready && state_q != S_OUT) begin
				ov_q <= 1'b0;
			end
			if (mem_we) begin
				pv_q[waddr] <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (meas.valid) begin
						zx_q    <= meas.meas_x;
						zy_q    <= meas.meas_y;
						state_q <= S_XPRED;
					end
				end
				S_XPRED: begin
					for (int g = 0; g < MAX_STATES; g++) begin
						xv_q[g] <= xp[g];
					end
					if (!locked_q && zx_q > 0 && zy_q > 0) begin
						locked_q <= 1'b1;
					end
					i_q     <= '0;
					j_q     <= '0;
					k_q     <= '0;
					ph_q    <= 1'b0;
					ri_q    <= '0;
					rj_q    <= '0;
					tag_q   <= T_PRED;
					state_q <= S_RD;
				end
				S_RD: state_q <= S_RDV;
				S_RDV: begin
					state_q <= S_RD;
					case (tag_q)
						T_PRED: begin
							acc_q <= (k_q == 2'd0) ? term : fx_add(acc_q, term);
							if (more) begin
								k_q <= k_q + 2'd1;
								if (ph_q) begin
									rj_q <= CW'(j_q + CW'(k_q) + CW'(1));
								end else begin
									ri_q <= CW'(i_q + CW'(k_q) + CW'(1));
								end
							end else begin
								state_q <= S_PWR;
							end
						end
						T_ROW0: begin
							row0_q[j_q[IW-1:0]] <= p_rd;
							if (j_q == '0) begin
								s00_q <= fx_add(p_rd, rnoise);
							end
							if (j_q == mst) begin
								s01_q <= p_rd;
							end
							tag_q <= T_ROWM;
							ri_q  <= mst;
						end
						T_ROWM: begin
							rowm_q[j_q[IW-1:0]] <= p_rd;
							if (j_q == '0) begin
								l_q <= p_rd;
							end
							if (j_q == mst) begin
								s11b_q <= fx_add(p_rd, rnoise);
							end
							if (j_q == CW'(nst - CW'(1))) begin
								state_q <= S_SETUP;
							end else begin
								j_q   <= CW'(j_q + CW'(1));
								ri_q  <= '0;
								rj_q  <= CW'(j_q + CW'(1));
								tag_q <= T_ROW0;
							end
						end
						T_B0: begin
							b0_q  <= p_rd;
							tag_q <= T_B1;
							ri_q  <= i_q;
							rj_q  <= mst;
						end
						T_B1: begin
							b1_q    <= p_rd;
							step_q  <= ST_Y1A;
							state_q <= S_ISSUE;
						end
						default: begin
							tmp_q   <= p_rd;
							step_q  <= ST_P0;
							state_q <= S_ISSUE;
						end
					endcase
				end
				S_PWR: begin
					k_q     <= '0;
					state_q <= S_RD;
					if (j_q != CW'(nst - CW'(1))) begin
						j_q  <= CW'(j_q + CW'(1));
						ri_q <= i_q;
						rj_q <= CW'(j_q + CW'(1));
					end else if (i_q != CW'(nst - CW'(1))) begin
						i_q  <= CW'(i_q + CW'(1));
						j_q  <= '0;
						ri_q <= CW'(i_q + CW'(1));
						rj_q <= '0;
					end else if (!ph_q) begin
						ph_q <= 1'b1;
						i_q  <= '0;
						j_q  <= '0;
						ri_q <= '0;
						rj_q <= '0;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					// skip the correction when either coordinate is unobserved
					if (zx_q < 0 || zy_q < 0) begin
						state_q <= S_OUT;
					end else begin
						j_q     <= '0;
						ri_q    <= '0;
						rj_q    <= '0;
						tag_q   <= T_ROW0;
						state_q <= S_RD;
					end
				end
				S_SETUP: begin
					e0_q    <= fx_sub(zx16, xv_q[0]);
					e1_q    <= fx_sub(zy16, xm);
					step_q  <= ST_L;
					state_q <= S_ISSUE;
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (ar_rsp.done) begin
						state_q <= S_ISSUE;
						case (step_q)
							ST_L: begin
								l_q    <= ar_res;
								step_q <= ST_S11;
							end
							ST_S11: begin
								s11b_q  <= fx_sub(s11b_q, ar_res);
								i_q     <= '0;
								ri_q    <= '0;
								rj_q    <= '0;
								tag_q   <= T_B0;
								state_q <= S_RD;
							end
							ST_Y1A: begin
								tmp_q  <= fx_sub(b1_q, ar_res);
								step_q <= ST_Y1;
							end
							ST_Y1: begin
								y1_q   <= ar_res;
								step_q <= ST_Y0A;
							end
							ST_Y0A: begin
								tmp_q  <= fx_sub(b0_q, ar_res);
								step_q <= ST_Y0;
							end
							ST_Y0: begin
								y0_q   <= ar_res;
								step_q <= ST_X0;
							end
							ST_X0: begin
								tmp_q  <= fx_add(xv_q[i_q[IW-1:0]], ar_res);
								step_q <= ST_X1;
							end
							ST_X1: begin
								xv_q[i_q[IW-1:0]] <= fx_add(tmp_q, ar_res);
								j_q     <= '0;
								ri_q    <= i_q;
								rj_q    <= '0;
								tag_q   <= T_PIJ;
								state_q <= S_RD;
							end
							ST_P0: begin
								tmp_q  <= fx_sub(tmp_q, ar_res);
								step_q <= ST_P1;
							end
							default: begin
								// row element written back through the memory port
								if (j_q != CW'(nst - CW'(1))) begin
									j_q     <= CW'(j_q + CW'(1));
									ri_q    <= i_q;
									rj_q    <= CW'(j_q + CW'(1));
									tag_q   <= T_PIJ;
									state_q <= S_RD;
								end else if (i_q != CW'(nst - CW'(1))) begin
									i_q     <= CW'(i_q + CW'(1));
									ri_q    <= CW'(i_q + CW'(1));
									rj_q    <= '0;
									tag_q   <= T_B0;
									state_q <= S_RD;
								end else begin
									state_q <= S_OUT;
								end
							end
						endcase
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (!ov_q || est.ready) begin
						estx_q  <= to_coord(xv_q[0]);
						esty_q  <= to_coord(xm);
						trk_q   <= locked_q;
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: tb/kalman_tracker_2d_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kalman_tracker_2d_core_test
// Drives measurement frames through the tracker under several register
// settings and compares each position estimate with a fixed-point Kalman
// predictor kept inside the bench.
// ---------------------------------------------------------------------------
module kalman_tracker_2d_core_test import kt2d_pkg::*;;

	localparam int CB = 13;
	localparam longint Q_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint Q_MIN = -Q_MAX - 1;
	localparam longint ONE = 65536;
	localparam longint HALF = 32768;

	typedef enum int {
		REG_MODEL = 0, REG_POS_NOISE = 1, REG_VEL_NOISE = 2, REG_ACC_NOISE = 3,
		REG_MEAS_NOISE = 4, REG_INIT_VAR = 5, REG_SPARE = 6
	} reg_idx_e;

	typedef struct packed {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
	} meas_t;

	typedef struct packed {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic                 tracking;
	} estimate_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	kt2d_meas_if #(.COORD_BITS(CB)) meas_ch ();
	kt2d_est_if #(.COORD_BITS(CB)) est_ch ();

	kalman_tracker_2d_core #(.MAX_STATES(6), .COORD_BITS(CB)) i_dut (
		.clk(clk), .arst_n(arst_n), .meas(meas_ch.sink), .est(est_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// tracker copy: registers, state, covariance, lock
	bit     cfg_model;
	longint cfg_pos, cfg_vel, cfg_acc, cfg_meas, cfg_init;
	fx_t    trk_x[6];
	fx_t    trk_p[6][6];
	bit     trk_locked;

	meas_t     frame_queue[$];
	estimate_t estimate_queue[$];
	int        errors = 0;
	bit        idle_en = 1;

	function automatic longint clamp48(longint v);
		if (v > Q_MAX) return Q_MAX;
		if (v < Q_MIN) return Q_MIN;
		return v;
	endfunction

	function automatic fx_t q_add(fx_t a, fx_t b);
		return fx_t'(clamp48(longint'(a) + longint'(b)));
	endfunction

	function automatic fx_t q_sub(fx_t a, fx_t b);
		return fx_t'(clamp48(longint'(a) - longint'(b)));
	endfunction

	function automatic logic [63:0] mag_of(fx_t v);
		longint w;
		w = v;
		return w < 0 ? 64'(-w) : 64'(w);
	endfunction

	function automatic fx_t apply_sign(logic [63:0] mag, bit neg);
		if (neg) begin
			if (mag > (64'd1 << 47)) mag = 64'd1 << 47;
			return fx_t'(-longint'(mag));
		end
		if (mag > 64'(Q_MAX)) mag = 64'(Q_MAX);
		return fx_t'(mag);
	endfunction

	// product rounded on magnitude, ties away from zero
	function automatic fx_t q_mul(fx_t a, fx_t b);
		logic [63:0] ua, ub, ah, al, bh, bl, hh, mid, ll, mag;
		ua = mag_of(a);
		ub = mag_of(b);
		ah = ua >> 24;
		al = ua & 64'hFF_FFFF;
		bh = ub >> 24;
		bl = ub & 64'hFF_FFFF;
		hh = ah * bh;
		mid = ah * bl + al * bh;
		ll = al * bl + 64'd32768;
		if (hh >= 64'd32768) mag = 64'd1 << 48;
		else mag = (hh << 32) + (mid << 8) + (ll >> 16);
		return apply_sign(mag, a[47] != b[47]);
	endfunction

	function automatic fx_t q_div(fx_t a, fx_t b);
		logic [63:0] ua, ub;
		ua = mag_of(a);
		ub = mag_of(b);
		if (ub == 0) return '0;
		return apply_sign((ua << 16) / ub, a[47] != b[47]);
	endfunction

	function automatic fx_t trans(int i, int j, int m);
		int d;
		if ((i < m) != (j < m)) return '0;
		d = j - i;
		if (d == 0 || d == 1) return fx_t'(ONE);
		if (d == 2) return fx_t'(HALF);
		return '0;
	endfunction

	function automatic logic signed [CB-1:0] to_pixel(fx_t v);
		longint t, q;
		t = longint'(v) + HALF;
		if (t >= 0) q = t >>> 16;
		else q = -longint'((64'(-t) + 64'd65535) >> 16);
		if (q > 4095) q = 4095;
		if (q < -4096) q = -4096;
		return CB'(q);
	endfunction

	function automatic void restart_track();
		for (int i = 0; i < 6; i++) begin
			trk_x[i] = '0;
			for (int j = 0; j < 6; j++) trk_p[i][j] = (i == j) ? fx_t'(cfg_init * ONE) : '0;
		end
		trk_locked = 0;
	endfunction

	function automatic void apply_reg(int idx, longint value);
		case (idx)
			REG_MODEL: begin cfg_model = value[0]; restart_track(); end
			REG_POS_NOISE: cfg_pos = value & 16'hFFFF;
			REG_VEL_NOISE: cfg_vel = value & 16'hFFFF;
			REG_ACC_NOISE: cfg_acc = value & 16'hFFFF;
			REG_MEAS_NOISE: cfg_meas = value & 16'hFFFF;
			REG_INIT_VAR: begin cfg_init = value & 24'hFF_FFFF; restart_track(); end
			default: ;
		endcase
	endfunction

	// one frame: predict, lock handling, optional correction
	function automatic estimate_t track_frame(meas_t z);
		int n, m, r;
		fx_t x[6], t[6][6], p[6][6], row0[6], rowm[6];
		fx_t acc, zx16, zy16, rr, s00, s01, s10, s11, l, s11b, e0, e1, b0, b1, y0, y1;
		longint zx, zy, qn;
		estimate_t e;
		n = cfg_model ? 6 : 4;
		m = n / 2;
		zx = z.x;
		zy = z.y;
		zx16 = fx_t'(zx * ONE);
		zy16 = fx_t'(zy * ONE);
		for (int i = 0; i < n; i++) begin
			acc = '0;
			for (int j = 0; j < n; j++) acc = q_add(acc, q_mul(trans(i, j, m), trk_x[j]));
			x[i] = acc;
		end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				acc = '0;
				for (int k = 0; k < n; k++) acc = q_add(acc, q_mul(trans(i, k, m), trk_p[k][j]));
				t[i][j] = acc;
			end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				acc = '0;
				for (int k = 0; k < n; k++) acc = q_add(acc, q_mul(t[i][k], trans(j, k, m)));
				if (i == j) begin
					r = i < m ? i : i - m;
					qn = r == 0 ? cfg_pos : (r == 1 ? cfg_vel : cfg_acc);
					acc = q_add(acc, fx_t'(qn * ONE));
				end
				p[i][j] = acc;
			end
		if (!trk_locked) begin
			x[0] = zx16;
			x[m] = zy16;
			if (zx > 0 && zy > 0) trk_locked = 1;
		end
		if (zx >= 0 && zy >= 0) begin
			rr = fx_t'(cfg_meas * ONE);
			s00 = q_add(p[0][0], rr);
			s01 = p[0][m];
			s10 = p[m][0];
			s11 = q_add(p[m][m], rr);
			l = q_div(s10, s00);
			s11b = q_sub(s11, q_mul(l, s01));
			e0 = q_sub(zx16, x[0]);
			e1 = q_sub(zy16, x[m]);
			for (int j = 0; j < n; j++) begin
				row0[j] = p[0][j];
				rowm[j] = p[m][j];
			end
			for (int i = 0; i < n; i++) begin
				b0 = p[i][0];
				b1 = p[i][m];
				y1 = q_div(q_sub(b1, q_mul(l, b0)), s11b);
				y0 = q_div(q_sub(b0, q_mul(s01, y1)), s00);
				x[i] = q_add(q_add(x[i], q_mul(y0, e0)), q_mul(y1, e1));
				for (int j = 0; j < n; j++)
					p[i][j] = q_sub(q_sub(p[i][j], q_mul(y0, row0[j])), q_mul(y1, rowm[j]));
			end
		end
		for (int i = 0; i < n; i++) begin
			trk_x[i] = x[i];
			for (int j = 0; j < n; j++) trk_p[i][j] = p[i][j];
		end
		e.x = to_pixel(trk_x[0]);
		e.y = to_pixel(trk_x[m]);
		e.tracking = trk_locked;
		return e;
	endfunction

	task automatic report_mismatch(string what);
		errors++;
		$display("%0t: mismatch: %s", $realtime, what);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// request driver
	int  gap_left = 0;
	meas_t cur;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_ch.valid <= 0;
			meas_ch.meas_x <= '0;
			meas_ch.meas_y <= '0;
		end else begin
			if (meas_ch.valid && meas_ch.ready) begin
				cur.x = meas_ch.meas_x;
				cur.y = meas_ch.meas_y;
				estimate_queue.insert(estimate_queue.size(), track_frame(cur));
				gap_left = idle_en ? $urandom_range(0, 7) : 0;
			end
			if (!meas_ch.valid || meas_ch.ready) begin
				if (gap_left > 0 || frame_queue.size() == 0) begin
					if (gap_left > 0) gap_left--;
					meas_ch.valid <= 0;
				end else begin
					cur = frame_queue.pop_front();
					meas_ch.meas_x <= cur.x;
					meas_ch.meas_y <= cur.y;
					meas_ch.valid <= 1;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	int cycle_cnt = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == 40000) hold_left = 8000;
		else if (hold_left > 0) hold_left--;
	end

	// estimate monitor and back-pressure
	int stall_left = 0;
	estimate_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_ch.ready <= 0;
		end else begin
			if (est_ch.valid && est_ch.ready) begin
				if (estimate_queue.size() == 0) begin
					report_mismatch("estimate with none pending");
				end else begin
					want = estimate_queue.pop_front();
					if (est_ch.est_x !== want.x)
						report_mismatch($sformatf("est_x %0d, want %0d", est_ch.est_x, want.x));
					if (est_ch.est_y !== want.y)
						report_mismatch($sformatf("est_y %0d, want %0d", est_ch.est_y, want.y));
					if (est_ch.tracking !== want.tracking)
						report_mismatch($sformatf("tracking %0b, want %0b",
							est_ch.tracking, want.tracking));
				end
				stall_left = idle_en ? $urandom_range(0, 7) : 0;
			end
			if (hold_left > 0) begin
				est_ch.ready <= 0;
			end else if (stall_left > 0) begin
				stall_left--;
				est_ch.ready <= 0;
			end else begin
				est_ch.ready <= 1;
			end
		end
	end

	task automatic write_reg(reg_idx_e idx, longint value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 5'(4 * int'(idx));
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		apply_reg(idx, value);
	endtask

	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (frame_queue.size() != 0 || meas_ch.valid || estimate_queue.size() != 0);
	endtask

	task automatic push_frame(int x, int y);
		meas_t f;
		f.x = CB'(x);
		f.y = CB'(y);
		frame_queue.insert(frame_queue.size(), f);
	endtask

	// moving target with jitter, dropouts and some noise frames
	task automatic push_tracks(int count);
		int px, py, vx, vy, r;
		px = $urandom_range(0, 4095);
		py = $urandom_range(0, 4095);
		vx = $urandom_range(0, 60) - 30;
		vy = $urandom_range(0, 60) - 30;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 39) == 0) begin
				px = $urandom_range(0, 4095);
				py = $urandom_range(0, 4095);
				vx = $urandom_range(0, 60) - 30;
				vy = $urandom_range(0, 60) - 30;
			end
			if ($urandom_range(0, 9) == 0) vx += $urandom_range(0, 4) - 2;
			if ($urandom_range(0, 9) == 0) vy += $urandom_range(0, 4) - 2;
			px += vx;
			py += vy;
			if (px < 0 || px > 4095) begin vx = -vx; px = px < 0 ? 0 : 4095; end
			if (py < 0 || py > 4095) begin vy = -vy; py = py < 0 ? 0 : 4095; end
			r = $urandom_range(0, 99);
			if (r < 5)
				push_frame($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096);
			else if (r < 10)
				push_frame(-int'($urandom_range(1, 4096)), py);
			else if (r < 15)
				push_frame(px, -int'($urandom_range(1, 4096)));
			else
				push_frame(px + $urandom_range(0, 6) - 3, py + $urandom_range(0, 6) - 3);
		end
	endtask

	task automatic set_all(bit model, int q_pos, int q_vel, int q_acc, int r_meas, int p0);
		write_reg(REG_POS_NOISE, q_pos);
		write_reg(REG_VEL_NOISE, q_vel);
		write_reg(REG_ACC_NOISE, q_acc);
		write_reg(REG_MEAS_NOISE, r_meas);
		write_reg(REG_INIT_VAR, p0);
		write_reg(REG_MODEL, model);
	endtask

	initial begin
		arst_n <= 0;
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		paddr <= '0;
		pwdata <= '0;
		cfg_model = 0;
		cfg_pos = 25;
		cfg_vel = 10;
		cfg_acc = 1;
		cfg_meas = 25;
		cfg_init = 1000000;
		restart_track();
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// unlocked zero, dropouts, then extremes, which take the lock
		push_frame(0, 0);
		push_frame(-1, 5);
		push_frame(5, -1);
		push_frame(-4096, -4096);
		push_frame(0, 4095);
		push_frame(4095, -4096);
		push_frame(4095, 4095);
		push_frame(-4096, 4095);
		push_frame(4095, 0);
		push_frame(1, 1);
		push_frame(0, 0);
		push_frame(100, 200);
		push_frame(-1, -1);
		push_tracks(200);
		wait_idle();

		write_reg(REG_MODEL, 1);
		idle_en = 0;
		push_frame(0, 0);
		push_frame(4095, 4095);
		push_frame(-4096, 10);
		push_frame(4095, 4095);
		push_tracks(220);
		wait_idle();
		idle_en = 1;

		// zero noise and zero covariance: divisors vanish
		set_all(0, 0, 0, 0, 0, 0);
		push_frame(0, 0);
		push_tracks(150);
		wait_idle();

		set_all(1, 65535, 65535, 65535, 65535, 16777215);
		push_frame(4095, 4095);
		push_frame(-4096, -4096);
		push_tracks(230);
		wait_idle();

		set_all(1, 0, 0, 0, 0, 0);
		push_tracks(150);
		wait_idle();

		set_all(0, 65535, 65535, 65535, 65535, 16777215);
		push_tracks(200);
		wait_idle();

		write_reg(REG_SPARE, $urandom);
		set_all($urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 16777215));
		push_tracks(150);
		wait_idle();

		set_all($urandom_range(0, 1), $urandom_range(0, 200), $urandom_range(0, 50),
			$urandom_range(0, 10), $urandom_range(0, 200), $urandom_range(0, 2000000));
		push_tracks(150);
		wait_idle();

		repeat (2000) @(posedge clk);
		if (estimate_queue.size() != 0) report_mismatch("estimates still pending");
		if (errors == 0) begin
			$display("kalman_tracker_2d_core_test passed");
		end else begin
			$display("kalman_tracker_2d_core_test failed");
		end
		$finish;
	end

	initial begin
		#100_000_000;
		$display("kalman_tracker_2d_core_test failed");
		$finish;
	end

endmodule
